@@ design/lfsf_pkg.sv @@
package lfsf_pkg;

  localparam int LED_MAX = 32;
  localparam int IDX_W   = $clog2(LED_MAX);
  localparam int CNT_W   = $clog2(LED_MAX + 1);
  localparam int WORD_W  = 24;

  localparam logic [1:0] OP_FILL_ALL = 2'd0;
  localparam logic [1:0] OP_FILL_ONE = 2'd1;
  localparam logic [1:0] OP_TOGGLE   = 2'd2;
  localparam logic [1:0] OP_NONE     = 2'd3;

  localparam logic [1:0] CH_GREEN = 2'd0;
  localparam logic [1:0] CH_RED   = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic [7:0] FULL_LEVEL = 8'd255;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_UPD  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] fill;
    logic [WORD_W-1:0] lane_mask;
    logic [7:0]        stride;
    logic              keep;
  } cmd_t;

endpackage

@@ design/lfsf_ram.sv @@
module lfsf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/led_frame_stride_fill.sv @@
// Frame store of 32 RGB LED words driven by one command per input word. A command
// first rewrites each active LED (read-modify-write through the frame memory, one LED
// per cycle), then streams every active LED word out in index order at up to one word
// per cycle, each carrying the lit flag of the new frame and the last one marked with
// out_last. Both passes share the single read port of the frame memory.
// Ignored commands (unused op or channel, zero stride) and commands with no active
// LEDs give no words. The next command is taken once the last word has left the
// memory read register, while that word may still wait at the output.
module led_frame_stride_fill (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_led_count,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [1:0] in_channel,
  input  logic [7:0] in_level,
  input  logic [7:0] in_stride,
  input  logic       in_keep_others,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_led_index,
  output logic [7:0] out_green,
  output logic [7:0] out_red,
  output logic [7:0] out_blue,
  output logic       out_last,
  output logic       out_any_lit
);
  import lfsf_pkg::*;

  state_t              state_r, state_nxt;
  logic [5:0]          led_count_r;
  logic [CNT_W-1:0]    active_r, active_nxt;
  logic                lit_flag_r, lit_flag_nxt;
  logic                lit_acc_r, lit_acc_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [CNT_W-1:0]    upd_idx_r, upd_idx_nxt;
  logic [7:0]          mod_r, mod_nxt;
  logic                s1_vld_r, s1_vld_nxt;
  logic [IDX_W-1:0]    s1_addr_r, s1_addr_nxt;
  logic                s1_sel_r, s1_sel_nxt;
  logic [CNT_W-1:0]    em_idx_r, em_idx_nxt;
  logic                pend_r, pend_nxt;
  logic [IDX_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic                pend_last_r, pend_last_nxt;
  logic                pend_wr_r, pend_wr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [LED_MAX-1:0]  written_r, written_nxt;
  logic [IDX_W-1:0]    out_idx_r;
  logic [WORD_W-1:0]   out_word_r;
  logic                out_last_r;
  logic                out_lit_r;

  logic                in_acc;
  logic                cmd_ok;
  logic [CNT_W-1:0]    active_in;
  logic [7:0]          tog_val;
  logic                upd_issue;
  logic                em_issue;
  logic                move;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic [WORD_W-1:0]   rd_data;
  logic [WORD_W-1:0]   s1_old;
  logic [WORD_W-1:0]   s1_base;
  logic [WORD_W-1:0]   s1_new;
  logic [WORD_W-1:0]   pend_word;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE) && !pend_r;
  assign in_acc    = in_valid && in_ready;

  assign active_in = (led_count_r > 6'(LED_MAX)) ? CNT_W'(LED_MAX) : CNT_W'(led_count_r);
  assign tog_val   = lit_flag_r ? 8'd0 : FULL_LEVEL;

  always_comb begin
    cmd_ok = 1'b1;
    cmd_nxt = cmd_r;
    case (in_op)
      OP_FILL_ALL: begin
        cmd_nxt.fill      = {in_green, in_red, in_blue};
        cmd_nxt.lane_mask = '1;
        cmd_nxt.stride    = in_stride;
        cmd_nxt.keep      = in_keep_others;
        cmd_ok            = (in_stride != 8'd0);
      end
      OP_FILL_ONE: begin
        cmd_nxt.fill      = {in_level, in_level, in_level};
        cmd_nxt.stride    = in_stride;
        cmd_nxt.keep      = in_keep_others;
        cmd_ok            = (in_stride != 8'd0);
        case (in_channel)
          CH_GREEN: cmd_nxt.lane_mask = {8'hff, 8'h00, 8'h00};
          CH_RED:   cmd_nxt.lane_mask = {8'h00, 8'hff, 8'h00};
          CH_BLUE:  cmd_nxt.lane_mask = {8'h00, 8'h00, 8'hff};
          default: begin
            cmd_nxt.lane_mask = '0;
            cmd_ok            = 1'b0;
          end
        endcase
      end
      OP_TOGGLE: begin
        cmd_nxt.fill      = {tog_val, tog_val, tog_val};
        cmd_nxt.lane_mask = '1;
        cmd_nxt.stride    = 8'd1;
        cmd_nxt.keep      = 1'b0;
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
  end

  // read-modify-write stage
  assign s1_old  = written_r[s1_addr_r] ? rd_data : '0;
  assign s1_base = s1_sel_r ? cmd_r.fill : (cmd_r.keep ? s1_old : '0);
  assign s1_new  = (s1_base & cmd_r.lane_mask) | (s1_old & ~cmd_r.lane_mask);

  assign upd_issue = (state_r == S_UPD) && (upd_idx_r < active_r);
  assign move      = pend_r && (!out_valid_r || out_ready);
  assign em_issue  = (state_r == S_EMIT) && (em_idx_r < active_r) && (!pend_r || move);
  assign rd_en     = upd_issue || em_issue;
  assign rd_addr   = (state_r == S_UPD) ? upd_idx_r[IDX_W-1:0] : em_idx_r[IDX_W-1:0];
  assign pend_word = pend_wr_r ? rd_data : '0;

  lfsf_ram #(
    .WIDTH (WORD_W),
    .DEPTH (LED_MAX)
  ) u_frame (
    .clk     (clk),
    .wr_en   (s1_vld_r),
    .wr_addr (s1_addr_r),
    .wr_data (s1_new),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    lit_flag_nxt  = lit_flag_r;
    lit_acc_nxt   = lit_acc_r;
    upd_idx_nxt   = upd_idx_r;
    mod_nxt       = mod_r;
    s1_vld_nxt    = 1'b0;
    s1_addr_nxt   = s1_addr_r;
    s1_sel_nxt    = s1_sel_r;
    em_idx_nxt    = em_idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    pend_last_nxt = pend_last_r;
    pend_wr_nxt   = pend_wr_r;
    out_valid_nxt = out_valid_r;
    written_nxt   = written_r;

    if (s1_vld_r) begin
      written_nxt[s1_addr_r] = 1'b1;
      lit_acc_nxt = lit_acc_r || (s1_new != '0);
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && cmd_ok) begin
          if (active_in == '0) begin
            lit_flag_nxt = 1'b0;
          end else begin
            active_nxt  = active_in;
            upd_idx_nxt = '0;
            mod_nxt     = '0;
            lit_acc_nxt = 1'b0;
            state_nxt   = S_UPD;
          end
        end
      end
      S_UPD: begin
        if (upd_issue) begin
          upd_idx_nxt = upd_idx_r + CNT_W'(1);
          mod_nxt     = (mod_r == cmd_r.stride - 8'd1) ? 8'd0 : mod_r + 8'd1;
          s1_vld_nxt  = 1'b1;
          s1_addr_nxt = upd_idx_r[IDX_W-1:0];
          s1_sel_nxt  = (mod_r == 8'd0);
        end else if (!s1_vld_r) begin
          lit_flag_nxt = lit_acc_r;
          em_idx_nxt   = '0;
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (em_idx_r == active_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (move) begin
      pend_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (em_issue) begin
      em_idx_nxt    = em_idx_r + CNT_W'(1);
      pend_nxt      = 1'b1;
      pend_idx_nxt  = em_idx_r[IDX_W-1:0];
      pend_last_nxt = (em_idx_r + CNT_W'(1) == active_r);
      pend_wr_nxt   = written_r[em_idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      led_count_r <= '0;
      active_r    <= '0;
      lit_flag_r  <= 1'b0;
      lit_acc_r   <= 1'b0;
      upd_idx_r   <= '0;
      mod_r       <= '0;
      s1_vld_r    <= 1'b0;
      em_idx_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      written_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        led_count_r <= cfg_led_count;
      end
      active_r    <= active_nxt;
      lit_flag_r  <= lit_flag_nxt;
      lit_acc_r   <= lit_acc_nxt;
      upd_idx_r   <= upd_idx_nxt;
      mod_r       <= mod_nxt;
      s1_vld_r    <= s1_vld_nxt;
      em_idx_r    <= em_idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      written_r   <= written_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= cmd_nxt;
    end
    s1_addr_r   <= s1_addr_nxt;
    s1_sel_r    <= s1_sel_nxt;
    pend_idx_r  <= pend_idx_nxt;
    pend_last_r <= pend_last_nxt;
    pend_wr_r   <= pend_wr_nxt;
    if (move) begin
      out_idx_r  <= pend_idx_r;
      out_word_r <= pend_word;
      out_last_r <= pend_last_r;
      out_lit_r  <= lit_flag_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_led_index = out_idx_r;
  assign out_green     = out_word_r[23:16];
  assign out_red       = out_word_r[15:8];
  assign out_blue      = out_word_r[7:0];
  assign out_last      = out_last_r;
  assign out_any_lit   = out_lit_r;

  // a new read never overwrites a word still held in the read register
  a_no_read_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && pend_r) |-> move)
    else $error("frame read overwrote a pending word");

  // writes stay inside the active range
  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> (CNT_W'(s1_addr_r) < active_r))
    else $error("frame write beyond active count");

  // update writes only follow reads of the update pass
  a_wr_follows_upd: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> ($past(upd_issue) && (state_r == S_UPD)))
    else $error("frame write outside update pass");

  // no command taken while emission still in flight
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (!pend_r && !s1_vld_r))
    else $error("command accepted while busy");

endmodule
